FILE: design/ecd_pkg.sv
// Package for the elevator call dispatcher: payload structs, policy codes,
// floor limits and the search result bundle. No dependencies.
`default_nettype none

package ecd_pkg;

    // Number of floors the car hardware can address. The call bitmap is fixed at 16 bits.
    localparam int FLOOR_COUNT = 16;
    localparam int FLOOR_W     = 4;
    localparam int MASK_W      = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    // Highest floor the datapath may ever use, limited by the 4-bit floor fields.
    localparam int MAX_TOP = (FLOOR_COUNT - 1 > 15) ? 15 : FLOOR_COUNT - 1;

    // Dispatch policy codes.
    localparam logic [MODE_W-1:0] MODE_CLOSEST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EARLIEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWEEP    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_FLOOR = 1'd1;

    localparam logic [MODE_W-1:0]  MODE_RESET      = MODE_EARLIEST;
    localparam logic [FLOOR_W-1:0] TOP_FLOOR_RESET = 4'd15;

    typedef struct packed {
        logic [FLOOR_W-1:0] current_floor;
        logic [MASK_W-1:0]  pending_mask;
        logic [FLOOR_W-1:0] oldest_floor;
    } t_in_item;

    typedef struct packed {
        logic [FLOOR_W-1:0] target_floor;
        logic               found;
        logic               heading_up;
    } t_out_item;

    // Nearest pending floor at or above and at or below the car.
    typedef struct packed {
        logic               any_call;
        logic               up_hit;
        logic [FLOOR_W-1:0] up_floor;
        logic               dn_hit;
        logic [FLOOR_W-1:0] dn_floor;
        logic [FLOOR_W-1:0] cur_floor;
    } t_search;

endpackage

`default_nettype wire

FILE: design/ecd_search.sv
// Floor search: clamps the car floor and the call bitmap to the served range
// and finds the nearest call on each side. Depends on ecd_pkg.
`default_nettype none

module ecd_search (
    input  wire logic [ecd_pkg::FLOOR_W-1:0] i_top_floor,
    input  wire logic [ecd_pkg::FLOOR_W-1:0] i_current_floor,
    input  wire logic [ecd_pkg::MASK_W-1:0]  i_pending_mask,
    output ecd_pkg::t_search                 o_search
);
    import ecd_pkg::*;

    logic [FLOOR_W-1:0] top_eff;
    logic [FLOOR_W-1:0] cur_eff;
    logic [MASK_W-1:0]  mask_eff;

    always_comb begin
        top_eff = (i_top_floor > FLOOR_W'(MAX_TOP)) ? FLOOR_W'(MAX_TOP) : i_top_floor;
        cur_eff = (i_current_floor > top_eff) ? top_eff : i_current_floor;
        for (int n = 0; n < MASK_W; n++) begin
            mask_eff[n] = i_pending_mask[n] && (FLOOR_W'(n) <= top_eff);
        end
    end

    // Two priority encoders: lowest call at or above the car, highest at or below.
    always_comb begin
        o_search           = '0;
        o_search.cur_floor = cur_eff;
        o_search.any_call  = |mask_eff;
        for (int n = MASK_W - 1; n >= 0; n--) begin
            if (mask_eff[n] && (FLOOR_W'(n) >= cur_eff)) begin
                o_search.up_hit   = 1'b1;
                o_search.up_floor = FLOOR_W'(n);
            end
        end
        for (int n = 0; n < MASK_W; n++) begin
            if (mask_eff[n] && (FLOOR_W'(n) <= cur_eff)) begin
                o_search.dn_hit   = 1'b1;
                o_search.dn_floor = FLOOR_W'(n);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/ecd_policy.sv
// Dispatch policy: turns the search result into a target floor, a found flag
// and the next sweep direction. Depends on ecd_pkg.
`default_nettype none

module ecd_policy (
    input  wire logic [ecd_pkg::MODE_W-1:0]  i_mode,
    input  wire logic                        i_heading_up,
    input  wire logic [ecd_pkg::FLOOR_W-1:0] i_oldest_floor,
    input  wire ecd_pkg::t_search            i_search,
    output ecd_pkg::t_out_item               o_result
);
    import ecd_pkg::*;

    logic               take_up;
    logic [FLOOR_W-1:0] up_dist;
    logic [FLOOR_W-1:0] dn_dist;

    always_comb begin
        up_dist = i_search.up_floor - i_search.cur_floor;
        dn_dist = i_search.cur_floor - i_search.dn_floor;
        // On a tie the upper floor wins.
        take_up = i_search.up_hit && (!i_search.dn_hit || (up_dist <= dn_dist));

        o_result            = '0;
        o_result.heading_up = i_heading_up;
        if (i_search.any_call) begin
            case (i_mode)
                MODE_CLOSEST: begin
                    o_result.found        = 1'b1;
                    o_result.target_floor = take_up ? i_search.up_floor : i_search.dn_floor;
                end
                MODE_EARLIEST: begin
                    o_result.found        = 1'b1;
                    o_result.target_floor = i_oldest_floor;
                end
                MODE_SWEEP: begin
                    o_result.found = 1'b1;
                    if (i_heading_up) begin
                        if (i_search.up_hit) begin
                            o_result.target_floor = i_search.up_floor;
                        end else begin
                            o_result.target_floor = i_search.dn_floor;
                            o_result.heading_up   = 1'b0;
                        end
                    end else begin
                        if (i_search.dn_hit) begin
                            o_result.target_floor = i_search.dn_floor;
                        end else begin
                            o_result.target_floor = i_search.up_floor;
                            o_result.heading_up   = 1'b1;
                        end
                    end
                end
                default: begin
                    o_result.found = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/elevator_call_dispatcher_top.sv
// Top level of the elevator call dispatcher: input register, search and policy
// logic, result register, configuration registers. Depends on ecd_pkg,
// ecd_search and ecd_policy.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+---------------------
//   in       | in        | i_in_valid / o_in_ready      | i_in_data  (t_in_item)
//   out      | out       | o_out_valid / i_out_ready    | o_out_data (t_out_item)
//   cfg      | in        | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// An item is captured in the input register and then moves to the result
// register, from which it is presented and can leave. The pipeline takes one
// item per cycle while the result register is not stalled; the only loop is
// the one-bit sweep direction, which is updated as the item leaves the input
// register.
// Reset (synchronous, active low) empties both stages, sets mode to earliest
// call, top floor to 15 and the sweep direction to up.
// A stalled result register holds its item; the input register then holds
// too, and o_in_ready drops only when both stages are full and the result is
// not being taken in that cycle.
`default_nettype none

module elevator_call_dispatcher_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire ecd_pkg::t_in_item              i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output ecd_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [ecd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ecd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ecd_pkg::*;

    // Configuration registers.
    logic [MODE_W-1:0]  r_mode;
    logic [FLOOR_W-1:0] r_top_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESET;
            r_top_floor <= TOP_FLOOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:      r_mode      <= i_cfg_data[MODE_W-1:0];
                CFG_TOP_FLOOR: r_top_floor <= i_cfg_data[FLOOR_W-1:0];
                default:       r_mode      <= r_mode;
            endcase
        end
    end

    // Stage control: the input stage moves forward whenever the result
    // register is empty or is being emptied in this cycle.
    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    t_out_item r_out_item;
    logic     r_heading_up;
    logic     advance;
    logic     n_in_valid;
    logic     n_out_valid;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !advance);
    assign n_out_valid = advance ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // Search and policy between the two registers.
    t_search   search;
    t_out_item result;

    ecd_search u_search (
        .i_top_floor     (r_top_floor),
        .i_current_floor (r_in_item.current_floor),
        .i_pending_mask  (r_in_item.pending_mask),
        .o_search        (search)
    );

    ecd_policy u_policy (
        .i_mode         (r_mode),
        .i_heading_up   (r_heading_up),
        .i_oldest_floor (r_in_item.oldest_floor),
        .i_search       (search),
        .o_result       (result)
    );

    // The sweep direction follows each item as it is committed to the result
    // register, so the next item already sees the updated direction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading_up <= 1'b1;
        end else if (r_in_valid && advance) begin
            r_heading_up <= result.heading_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire

FILE: design/ecd_checker.sv
// Port-level checker for the elevator call dispatcher, bound to the top level.
// Depends on ecd_pkg.
`default_nettype none

module ecd_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_ready,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire ecd_pkg::t_out_item  i_out_data
);
    import ecd_pkg::*;

    // A result that waits is held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed while stalled");

    // Input back-pressure only comes from a stalled, full result register.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without a stalled result");

    // No target is reported when nothing is found.
    a_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.found) |-> (i_out_data.target_floor == '0))
        else $error("target floor set while nothing found");

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind elevator_call_dispatcher_top ecd_checker u_ecd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for elevator_call_dispatcher_top: a directed table,
// then random items under several register settings, all checked in order.
// Depends on ecd_pkg and the dispatcher RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecd_pkg::*;

    // The mode register holds two bits, so code 3 can be written; it selects nothing.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int N_DIRECTED   = 19;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int SETTLE_TICKS = 8;
    localparam int MAX_REPORTS  = 10;

    // Clock, reset and every input of the block start at known values.
    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    elevator_call_dispatcher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the block's registers and of its sweep direction.
    logic [MODE_W-1:0]  policy    = MODE_RESET;
    logic [FLOOR_W-1:0] top_limit = TOP_FLOOR_RESET;
    logic               sweep_up  = 1'b1;

    t_out_item decision_q[$];
    int        mismatches = 0;
    bit        idling_on  = 1'b1;

    // Works out the decision for one item and advances the sweep direction the
    // same way the block does. Only the sweep policy touches the direction.
    function automatic t_out_item dispatch_decision(t_in_item it);
        t_out_item          res;
        logic [15:0]        calls;
        int                 top;
        int                 cur;
        int                 d;
        int                 f;
        int                 pass;
        bit                 hit;
        res   = '0;
        hit   = 1'b0;
        top   = (int'(top_limit) > MAX_TOP) ? MAX_TOP : int'(top_limit);
        cur   = (int'(it.current_floor) > top) ? top : int'(it.current_floor);
        calls = it.pending_mask & 16'((32'd2 << top) - 1);
        if (calls != '0) begin
            case (policy)
                MODE_CLOSEST: begin
                    // Looking up first at each distance makes the upper floor win a tie.
                    for (d = 0; d <= top && !hit; d++) begin
                        if (cur + d <= top && calls[cur + d]) begin
                            res.target_floor = FLOOR_W'(cur + d);
                            hit = 1'b1;
                        end else if (cur - d >= 0 && calls[cur - d]) begin
                            res.target_floor = FLOOR_W'(cur - d);
                            hit = 1'b1;
                        end
                    end
                end
                MODE_EARLIEST: begin
                    res.target_floor = it.oldest_floor;
                    hit = 1'b1;
                end
                MODE_SWEEP: begin
                    for (pass = 0; pass < 2 && !hit; pass++) begin
                        if (sweep_up) begin
                            for (f = cur; f <= top && !hit; f++) begin
                                if (calls[f]) begin
                                    res.target_floor = FLOOR_W'(f);
                                    hit = 1'b1;
                                end
                            end
                        end else begin
                            for (f = cur; f >= 0 && !hit; f--) begin
                                if (calls[f]) begin
                                    res.target_floor = FLOOR_W'(f);
                                    hit = 1'b1;
                                end
                            end
                        end
                        if (!hit) sweep_up = ~sweep_up;
                    end
                end
                default: ;
            endcase
        end
        res.found      = hit;
        res.heading_up = sweep_up;
        return res;
    endfunction

    // The receiver drops ready in random bursts while idling is on.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Every result that leaves the block is matched against the oldest decision
    // still waiting. The values read here are those the edge itself sampled.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (decision_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: target %0d found %0b up %0b",
                             $realtime, out_data.target_floor, out_data.found,
                             out_data.heading_up);
            end else begin
                want = decision_q.pop_front();
                if (out_data.target_floor !== want.target_floor ||
                    out_data.found !== want.found ||
                    out_data.heading_up !== want.heading_up) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $write("%0t: mismatch: expected target %0d found %0b up %0b,",
                               $realtime, want.target_floor, want.found, want.heading_up);
                        $display(" got target %0d found %0b up %0b",
                                 out_data.target_floor, out_data.found, out_data.heading_up);
                    end
                end
            end
        end
    end

    // Offers one item, with an optional random gap first, and waits until the
    // block takes it. The decision is recorded at the accepting edge.
    task automatic offer_item(t_in_item it, bit typed, t_out_item want);
        t_out_item predicted;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        predicted = dispatch_decision(it);
        decision_q.push_back(typed ? want : predicted);
    endtask

    // Registers change only with the block empty: every decision returned and the
    // two pipeline stages left to settle. Both registers are written one after
    // the other; spare upper bits of the mode write are random.
    task automatic set_policy(logic [MODE_W-1:0] m, logic [FLOOR_W-1:0] top);
        in_valid <= 1'b0;
        while (decision_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MODE;
        cfg_data <= {2'($urandom_range(0, 3)), m};
        @(posedge i_clk);
        cfg_idx  <= CFG_TOP_FLOOR;
        cfg_data <= top;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        policy    = m;
        top_limit = top;
    endtask

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [FLOOR_W-1:0] top;
        t_in_item           item;
        bit                 typed;
        t_out_item          want;
    } t_plan_row;

    t_plan_row plan[N_DIRECTED];

    initial begin
        t_in_item           it;
        logic [MODE_W-1:0]  m;
        logic [FLOOR_W-1:0] top;
        int                 sel;

        // Directed rows. Rows with a typed answer are read straight off the
        // policies; the rest rely on the predictor. Item fields are
        // {current_floor, pending_mask, oldest_floor}, answers {target, found, up}.
        plan = '{
            // Reset settings: no call pending gives no target.
            '{MODE_EARLIEST, 4'd15, {4'd0, 16'h0000, 4'd5}, 1'b1, {4'd0, 1'b0, 1'b1}},
            // Earliest call is taken as given, even where its bit is clear.
            '{MODE_EARLIEST, 4'd15, {4'd3, 16'h0001, 4'd15}, 1'b1, {4'd15, 1'b1, 1'b1}},
            '{MODE_EARLIEST, 4'd15, {4'd15, 16'hFFFF, 4'd0}, 1'b1, {4'd0, 1'b1, 1'b1}},
            // Closest call at the extremes of the building.
            '{MODE_CLOSEST, 4'd15, {4'd15, 16'h8000, 4'd0}, 1'b1, {4'd15, 1'b1, 1'b1}},
            '{MODE_CLOSEST, 4'd15, {4'd0, 16'h8000, 4'd0}, 1'b1, {4'd15, 1'b1, 1'b1}},
            // Tie between floors 3 and 7 seen from floor 5: the upper one wins.
            '{MODE_CLOSEST, 4'd15, {4'd5, 16'h0088, 4'd0}, 1'b1, {4'd7, 1'b1, 1'b1}},
            '{MODE_CLOSEST, 4'd15, {4'd9, 16'h0000, 4'd9}, 1'b1, {4'd0, 1'b0, 1'b1}},
            // Calls above a lowered top are dropped, and the car floor saturates.
            '{MODE_CLOSEST, 4'd7, {4'd15, 16'hFF00, 4'd0}, 1'b1, {4'd0, 1'b0, 1'b1}},
            '{MODE_CLOSEST, 4'd7, {4'd15, 16'h0101, 4'd0}, 1'b1, {4'd0, 1'b1, 1'b1}},
            // Sweep: ahead, then a reversal downward, the car's own floor, back up.
            '{MODE_SWEEP, 4'd15, {4'd4, 16'h0204, 4'd0}, 1'b0, '0},
            '{MODE_SWEEP, 4'd15, {4'd10, 16'h0004, 4'd0}, 1'b0, '0},
            '{MODE_SWEEP, 4'd15, {4'd2, 16'h0004, 4'd0}, 1'b0, '0},
            '{MODE_SWEEP, 4'd15, {4'd0, 16'h8000, 4'd0}, 1'b0, '0},
            '{MODE_SWEEP, 4'd15, {4'd7, 16'h0000, 4'd0}, 1'b0, '0},
            // The unused mode code chooses nothing.
            '{MODE_UNUSED, 4'd15, {4'd6, 16'hFFFF, 4'd6}, 1'b1, {4'd0, 1'b0, 1'b1}},
            // A top of zero serves only the ground floor.
            '{MODE_SWEEP, 4'd0, {4'd15, 16'hFFFF, 4'd0}, 1'b0, '0},
            '{MODE_CLOSEST, 4'd0, {4'd9, 16'hFFFE, 4'd0}, 1'b1, {4'd0, 1'b0, 1'b1}},
            '{MODE_EARLIEST, 4'd1, {4'd0, 16'h0002, 4'd12}, 1'b1, {4'd12, 1'b1, 1'b1}},
            '{MODE_EARLIEST, 4'd15, {4'd8, 16'h0000, 4'd3}, 1'b1, {4'd0, 1'b0, 1'b1}}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first row runs on the reset values; later rows rewrite the
        // registers whenever their setting differs from the current one.
        foreach (plan[r]) begin
            if (plan[r].mode != policy || plan[r].top != top_limit)
                set_policy(plan[r].mode, plan[r].top);
            offer_item(plan[r].item, plan[r].typed, plan[r].want);
        end

        // Random phases: a few fixed settings at the extremes, then random ones.
        // The last phase runs with no gaps on either side.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin m = MODE_CLOSEST; top = 4'd15; end
                1: begin m = MODE_SWEEP;   top = 4'd15; end
                2: begin m = MODE_SWEEP;   top = 4'd1;  end
                default: begin
                    m   = ($urandom_range(0, 7) == 0) ? MODE_UNUSED
                                                      : MODE_W'($urandom_range(0, 2));
                    top = FLOOR_W'($urandom_range(0, 15));
                end
            endcase
            set_policy(m, top);
            if (p == N_PHASES - 1) idling_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it.current_floor = FLOOR_W'($urandom_range(0, 15));
                it.oldest_floor  = FLOOR_W'($urandom_range(0, 15));
                sel = $urandom_range(0, 9);
                // Sparse call maps make the sweep reverse often; dense ones
                // exercise the tie and saturation paths.
                if (sel == 0) begin
                    it.pending_mask = '0;
                end else if (sel == 1) begin
                    it.pending_mask = '1;
                end else if (sel <= 5) begin
                    it.pending_mask = '0;
                    repeat ($urandom_range(1, 3))
                        it.pending_mask[$urandom_range(0, 15)] = 1'b1;
                end else begin
                    it.pending_mask = MASK_W'($urandom);
                end
                offer_item(it, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (decision_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Guard against a hung handshake: the run needs well under a tenth of this.
    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
design/ecd_pkg.sv
design/ecd_search.sv
design/ecd_policy.sv
design/elevator_call_dispatcher_top.sv
design/ecd_checker.sv
tb/sv/tb.sv
